FILE: rtl/secl_pkg.sv
// shared types and constants of the stx/etx command link
`default_nettype none
package secl_pkg;
	// request kinds
	localparam logic [1:0] REQ_BYTE   = 2'd0;
	localparam logic [1:0] REQ_TICK   = 2'd1;
	localparam logic [1:0] REQ_SENT   = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// framing bytes and commands
	localparam logic [7:0] CH_STX      = 8'h02;
	localparam logic [7:0] CH_ETX      = 8'h03;
	localparam logic [7:0] CH_ACK      = 8'h06;
	localparam logic [7:0] CMD_BEGIN   = 8'h42;
	localparam logic [7:0] CMD_END     = 8'h45;
	localparam logic [7:0] CMD_LED_OFF = 8'h49;
	localparam logic [7:0] CMD_LED_ON  = 8'h4F;
	localparam logic [7:0] CMD_SHIFT   = 8'h53;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;

	// action codes
	localparam logic [2:0] ACT_BEGIN     = 3'd0;
	localparam logic [2:0] ACT_END       = 3'd1;
	localparam logic [2:0] ACT_LED_ON    = 3'd2;
	localparam logic [2:0] ACT_LED_OFF   = 3'd3;
	localparam logic [2:0] ACT_SHIFT     = 3'd4;
	localparam logic [2:0] ACT_UNKNOWN   = 3'd5;
	localparam logic [2:0] ACT_FRAME_TO  = 3'd6;
	localparam logic [2:0] ACT_ACK_TO    = 3'd7;

	// configuration register indexes
	localparam logic REG_FRAME_TIMEOUT = 1'b0;
	localparam logic REG_ACK_TIMEOUT   = 1'b1;

	localparam logic [15:0] FRAME_TIMEOUT_RESET = 16'd1000;
	localparam logic [15:0] ACK_TIMEOUT_RESET   = 16'd2000;
	localparam logic [15:0] ARG_MAX             = 16'hFFFF;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] led_number;
		logic        send_ack;
		logic        connected;
	} secl_result_t;
endpackage
`default_nettype wire

FILE: rtl/secl_if.sv
// request and result channel interfaces of the command link
`default_nettype none
interface secl_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] rx_byte;
	modport source (output valid, output req_type, output rx_byte, input ready);
	modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface secl_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [15:0] led_number;
	logic        send_ack;
	logic        connected;
	modport source (output valid, output action, output led_number, output send_ack,
		output connected, input ready);
	modport sink (input valid, input action, input led_number, input send_ack,
		input connected, output ready);
endinterface
`default_nettype wire

FILE: rtl/secl_frame_engine.sv
// frame parser, command decoder and timer state of the command link
`default_nettype none
module secl_frame_engine
	import secl_pkg::*;
#(
	parameter int TIMER_WIDTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [1:0]   req_type,
	input  wire logic [7:0]   rx_byte,
	input  wire logic [15:0]  frame_timeout,
	input  wire logic [15:0]  ack_timeout,
	output logic              res_valid,
	output secl_result_t      res
);
	localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

	logic                   in_frame_q, have_cmd_q, digits_ended_q, link_up_q, ack_armed_q;
	logic [7:0]             cmd_q;
	logic [15:0]            arg_q;
	logic [TIMER_WIDTH-1:0] idle_cnt_q, ack_cnt_q;

	logic                   in_frame_n, have_cmd_n, digits_ended_n, link_up_n, ack_armed_n;
	logic [7:0]             cmd_n;
	logic [15:0]            arg_n;
	logic [TIMER_WIDTH-1:0] idle_cnt_n, ack_cnt_n;

	logic        do_dec, dec_timeout;
	logic [7:0]  dec_cmd;
	logic [15:0] dec_arg;
	logic [19:0] arg_mac;
	logic        is_digit, put_ack_to;

	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	// arg * 10 + digit
	assign arg_mac = {1'b0, arg_q, 3'b000} + {3'b000, arg_q, 1'b0}
		+ {16'd0, rx_byte[3:0] - CH_ZERO[3:0]};

	always_comb begin
		in_frame_n     = in_frame_q;
		have_cmd_n     = have_cmd_q;
		digits_ended_n = digits_ended_q;
		link_up_n      = link_up_q;
		ack_armed_n    = ack_armed_q;
		cmd_n          = cmd_q;
		arg_n          = arg_q;
		idle_cnt_n     = idle_cnt_q;
		ack_cnt_n      = ack_cnt_q;
		do_dec         = 1'b0;
		dec_timeout    = 1'b0;
		dec_cmd        = 8'd0;
		dec_arg        = 16'd0;
		put_ack_to     = 1'b0;
		res_valid      = 1'b0;
		res            = '0;

		case (req_type)
			REQ_BYTE: begin
				if (!in_frame_q) begin
					if (rx_byte == CH_ACK) begin
						ack_armed_n = 1'b0;
						ack_cnt_n   = '0;
					end else if (rx_byte == CH_STX) begin
						in_frame_n     = 1'b1;
						have_cmd_n     = 1'b0;
						cmd_n          = 8'd0;
						arg_n          = 16'd0;
						digits_ended_n = 1'b0;
						idle_cnt_n     = '0;
					end
				end else begin
					idle_cnt_n = '0;
					if (rx_byte == CH_ETX) begin
						in_frame_n = 1'b0;
						do_dec     = 1'b1;
						dec_cmd    = have_cmd_q ? cmd_q : 8'd0;
						dec_arg    = arg_q;
					end else if (!have_cmd_q) begin
						have_cmd_n = 1'b1;
						cmd_n      = rx_byte;
					end else if (!digits_ended_q) begin
						if (is_digit) begin
							arg_n = (arg_mac > {4'd0, ARG_MAX}) ? ARG_MAX : arg_mac[15:0];
						end else begin
							digits_ended_n = 1'b1;
						end
					end
				end
			end
			REQ_TICK: begin
				if (ack_armed_q && (ack_cnt_q != '1)) begin
					ack_cnt_n = ack_cnt_q + 1'b1;
				end
				if (in_frame_q) begin
					idle_cnt_n = (idle_cnt_q == '1) ? idle_cnt_q : idle_cnt_q + 1'b1;
					if (CW'(idle_cnt_n) >= CW'(frame_timeout)) begin
						in_frame_n  = 1'b0;
						idle_cnt_n  = '0;
						do_dec      = 1'b1;
						dec_timeout = 1'b1;
						dec_cmd     = CMD_END;
					end
				end else if (ack_armed_q && (CW'(ack_cnt_n) >= CW'(ack_timeout))) begin
					ack_armed_n = 1'b0;
					ack_cnt_n   = '0;
					if (link_up_q) begin
						link_up_n  = 1'b0;
						put_ack_to = 1'b1;
					end
				end
			end
			REQ_SENT: begin
				if (!ack_armed_q) begin
					ack_armed_n = 1'b1;
					ack_cnt_n   = '0;
				end
			end
			default: begin
			end
		endcase

		if (put_ack_to) begin
			res_valid = 1'b1;
			res.action = ACT_ACK_TO;
		end else if (do_dec) begin
			if (dec_cmd == CMD_BEGIN) begin
				link_up_n    = 1'b1;
				res_valid    = 1'b1;
				res.action   = ACT_BEGIN;
				res.send_ack = 1'b1;
			end else if (link_up_q) begin
				res_valid    = 1'b1;
				res.send_ack = 1'b1;
				case (dec_cmd)
					CMD_END: begin
						link_up_n  = 1'b0;
						res.action = dec_timeout ? ACT_FRAME_TO : ACT_END;
					end
					CMD_LED_ON: begin
						res.action     = ACT_LED_ON;
						res.led_number = dec_arg;
					end
					CMD_LED_OFF: begin
						res.action     = ACT_LED_OFF;
						res.led_number = dec_arg;
					end
					CMD_SHIFT: res.action = ACT_SHIFT;
					default:   res.action = ACT_UNKNOWN;
				endcase
			end
		end
		res.connected = link_up_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q     <= 1'b0;
			have_cmd_q     <= 1'b0;
			digits_ended_q <= 1'b0;
			link_up_q      <= 1'b0;
			ack_armed_q    <= 1'b0;
			cmd_q          <= 8'd0;
			arg_q          <= 16'd0;
			idle_cnt_q     <= '0;
			ack_cnt_q      <= '0;
		end else if (en) begin
			in_frame_q     <= in_frame_n;
			have_cmd_q     <= have_cmd_n;
			digits_ended_q <= digits_ended_n;
			link_up_q      <= link_up_n;
			ack_armed_q    <= ack_armed_n;
			cmd_q          <= cmd_n;
			arg_q          <= arg_n;
			idle_cnt_q     <= idle_cnt_n;
			ack_cnt_q      <= ack_cnt_n;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/stx_etx_command_link.sv
// top level of the stx/etx command link receiver
// an item is held in stage one, its result (if any) then in the result register
// throughput: one item per cycle while the result side keeps taking results
// the state feedback loop is the frame/timer state update in the frame engine
// reset: arst_n clears link, frame and timer state; timeouts return to 1000 and 2000
`default_nettype none
module stx_etx_command_link
	import secl_pkg::*;
#(
	parameter int TIMER_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	secl_req_if.sink         req,
	secl_res_if.source       res,
	input  wire logic        wr_en,
	input  wire logic        wr_index,
	input  wire logic [15:0] wr_data
);
	// configuration registers
	logic [15:0] frame_timeout_q, ack_timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_timeout_q <= FRAME_TIMEOUT_RESET;
			ack_timeout_q   <= ACK_TIMEOUT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_FRAME_TIMEOUT: frame_timeout_q <= wr_data;
				REG_ACK_TIMEOUT:   ack_timeout_q   <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// input register stage
	logic       valid_s1;
	logic [1:0] req_type_s1;
	logic [7:0] rx_byte_s1;
	logic       advance;

	// result register
	logic         res_valid_q;
	secl_result_t res_q;

	logic         eng_valid;
	secl_result_t eng_res;

	// the item in stage one moves on when the result register is free or drains now
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			rx_byte_s1  <= req.rx_byte;
		end
	end

	secl_frame_engine #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.req_type     (req_type_s1),
		.rx_byte      (rx_byte_s1),
		.frame_timeout(frame_timeout_q),
		.ack_timeout  (ack_timeout_q),
		.res_valid    (eng_valid),
		.res          (eng_res)
	);

	// items that cause no result just clear through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= eng_valid;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eng_valid) begin
			res_q <= eng_res;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.action     = res_q.action;
	assign res.led_number = res_q.led_number;
	assign res.send_ack   = res_q.send_ack;
	assign res.connected  = res_q.connected;
endmodule
`default_nettype wire

FILE: rtl/secl_checker.sv
// port-level checker of the command link and its bind
`default_nettype none
module secl_checker
	import secl_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [2:0]  action,
	input wire logic [15:0] led_number,
	input wire logic        send_ack,
	input wire logic        connected
);
	// ack timeout drops the link and sends no acknowledge
	a_ack_to: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (action == ACT_ACK_TO) |-> !send_ack && !connected)
		else $error("ack timeout result with ack or link up");

	// begin leaves the link up, end and frame timeout leave it down
	a_link: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((action == ACT_BEGIN) == connected) || (action == ACT_LED_ON)
			|| (action == ACT_LED_OFF) || (action == ACT_SHIFT) || (action == ACT_UNKNOWN))
		else $error("link flag does not match action");

	// only led actions carry a number
	a_led: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (action != ACT_LED_ON) && (action != ACT_LED_OFF) |-> led_number == 16'd0)
		else $error("led number on non-led action");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(action) && $stable(led_number)
			&& $stable(send_ack) && $stable(connected))
		else $error("stalled result changed");
endmodule

bind stx_etx_command_link secl_checker u_secl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.action    (res.action),
	.led_number(res.led_number),
	.send_ack  (res.send_ack),
	.connected (res.connected)
);
`default_nettype wire
